### design/nbtl_pkg.sv
// Shared constants and transfer types for the nearest bandwidth throttle lookup.
package nbtl_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = 9;
   localparam int BW_W        = 32;
   localparam int CODE_W      = 16;

   localparam logic [CODE_W-1:0] UNTHROTTLED_CODE = 16'h8fff;
   localparam logic [CNT_W-1:0]  DEPTH_CNT        = CNT_W'(TABLE_DEPTH);

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [7:0]        entry_index;
      logic [CODE_W-1:0] entry_reg_value;
      logic [BW_W-1:0]   entry_bandwidth;
      logic [BW_W-1:0]   target_bandwidth;
   } req_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] throttle_code;
      logic [7:0]        match_index;
      logic              bypassed;
   } rsp_item_type;

endpackage

### design/nearest_bandwidth_throttle_lookup.sv
// Top level: calibration table and sequential nearest-bandwidth search.
// Load transfers never raise busy.
// A query scans the table, one table entry compared per cycle by a single subtract/compare
// unit, then fetches the matching code and strobes the result; pair_count 0 or 1 skips the
// scan and an all-ones target skips both scan and fetch. The strobe lasts one cycle and the
// next start is taken the cycle after it. Synchronous reset clears the sequencer and
// pair_count; table contents are undefined.
module nearest_bandwidth_throttle_lookup (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  nbtl_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output nbtl_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [nbtl_pkg::CNT_W-1:0] csr_data
);
   import nbtl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_FETCH,
      ST_SEND
   } state_type;

   // Table storage
   logic [BW_W-1:0]   bw_mem   [TABLE_DEPTH];
   logic [CODE_W-1:0] code_mem [TABLE_DEPTH];

   // Control registers
   state_type         state_ff,     state_in;
   logic [CNT_W-1:0]  pair_count_ff;
   logic [CNT_W-1:0]  limit_ff,     limit_in;
   logic [CNT_W-1:0]  addr_ff,      addr_in;
   logic              cmp_valid_ff;
   logic              bypass_ff,    bypass_in;

   // Payload registers
   logic [BW_W-1:0]   target_ff,    target_in;
   logic [BW_W-1:0]   err_ff,       err_in;
   logic [IDX_W-1:0]  best_ff,      best_in;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic [BW_W-1:0]   bw_rd_ff;
   logic [CODE_W-1:0] code_rd_ff;

   logic              accept;
   logic              load_wr;
   logic [BW_W-1:0]   gap;
   logic              better;
   logic [CNT_W-1:0]  last_addr;
   logic [CNT_W-1:0]  clamp_count;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign load_wr   = accept && (req_item.req_type == REQ_LOAD);
   assign last_addr = limit_ff - CNT_W'(1);
   assign clamp_count = (pair_count_ff > DEPTH_CNT) ? DEPTH_CNT : pair_count_ff;

   // Shared compare unit: absolute gap against target, strict improvement test
   always_comb begin
      if (bw_rd_ff > target_ff) begin
         gap = bw_rd_ff - target_ff;
      end else begin
         gap = target_ff - bw_rd_ff;
      end
      better = cmp_valid_ff && (gap < err_ff);
   end

   // Sequencer next state
   always_comb begin
      state_in  = state_ff;
      limit_in  = limit_ff;
      addr_in   = addr_ff;
      bypass_in = bypass_ff;
      target_in = target_ff;
      err_in    = err_ff;
      best_in   = best_ff;
      if (better) begin
         err_in  = gap;
         best_in = cmp_idx_ff;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.req_type == REQ_QUERY)) begin
               target_in = req_item.target_bandwidth;
               err_in    = req_item.target_bandwidth;
               best_in   = '0;
               limit_in  = clamp_count;
               addr_in   = CNT_W'(1);
               if (req_item.target_bandwidth == '1) begin
                  bypass_in = 1'b1;
                  state_in  = ST_SEND;
               end else if (clamp_count <= CNT_W'(1)) begin
                  bypass_in = 1'b0;
                  state_in  = ST_FETCH;
               end else begin
                  bypass_in = 1'b0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + CNT_W'(1);
            if (addr_ff == last_addr) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST:  state_in = ST_FETCH;
         ST_FETCH: state_in = ST_SEND;
         ST_SEND:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Hold state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pair_count_ff <= '0;
         cmp_valid_ff  <= 1'b0;
         bypass_ff     <= 1'b0;
         limit_ff      <= '0;
         addr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= (state_ff == ST_SCAN);
         bypass_ff    <= bypass_in;
         limit_ff     <= limit_in;
         addr_ff      <= addr_in;
         if (csr_valid && csr_ready) begin
            pair_count_ff <= csr_data;
         end
      end
   end

   // Advance search payload
   always_ff @(posedge clock) begin
      target_ff  <= target_in;
      err_ff     <= err_in;
      best_ff    <= best_in;
      cmp_idx_ff <= addr_ff[IDX_W-1:0];
   end

   // Table write on load transfer, registered reads for scan and final fetch
   always_ff @(posedge clock) begin
      if (load_wr) begin
         bw_mem[req_item.entry_index[IDX_W-1:0]]   <= req_item.entry_bandwidth;
         code_mem[req_item.entry_index[IDX_W-1:0]] <= req_item.entry_reg_value;
      end
      bw_rd_ff   <= bw_mem[addr_ff[IDX_W-1:0]];
      code_rd_ff <= code_mem[best_ff];
   end

   // Drive result for one cycle
   assign rsp_strobe             = (state_ff == ST_SEND);
   assign rsp_item.throttle_code = bypass_ff ? UNTHROTTLED_CODE : code_rd_ff;
   assign rsp_item.match_index   = bypass_ff ? 8'd0 : 8'(best_ff);
   assign rsp_item.bypassed      = bypass_ff;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench: calibration table loads and nearest-bandwidth queries, scored.
module tb;
   import nbtl_pkg::*;

   localparam int HALF_PERIOD  = 1;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_TARGET  = 1950;
   localparam int PHASE_ITEMS  = 60;
   localparam int MAX_REPORTS  = 10;
   localparam logic [BW_W-1:0] BW_ALL_ONES = '1;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   req_item_type     req_item;
   logic             rsp_strobe;
   rsp_item_type     rsp_item;
   logic             csr_valid;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data;

   // Shadow copy of the calibration table and the pair count
   logic [CODE_W-1:0] cal_code [TABLE_DEPTH] = '{default: '0};
   logic [BW_W-1:0]   cal_bw   [TABLE_DEPTH] = '{default: '0};
   logic [CNT_W-1:0]  cal_count = '0;

   rsp_item_type pending_lookups[$];
   int           mismatch_count = 0;
   int           items_sent     = 0;
   bit           gaps_enabled   = 1'b1;

   nearest_bandwidth_throttle_lookup u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Work out the answer to a query from the shadow table
   function automatic rsp_item_type nearest_code(input logic [BW_W-1:0] target);
      rsp_item_type    answer;
      int              limit;
      int              best;
      logic [BW_W-1:0] err;
      logic [BW_W-1:0] gap;
      answer = '0;
      if (target == BW_ALL_ONES) begin
         answer.throttle_code = UNTHROTTLED_CODE;
         answer.bypassed      = 1'b1;
         return answer;
      end
      limit = (cal_count > DEPTH_CNT) ? TABLE_DEPTH : int'(cal_count);
      best  = 0;
      // error starts at the target, so an entry must beat it strictly
      err   = target;
      for (int i = 1; i < limit; i++) begin
         gap = (cal_bw[i] > target) ? cal_bw[i] - target : target - cal_bw[i];
         if (gap < err) begin
            best = i;
            err  = gap;
         end
      end
      answer.throttle_code = cal_code[best];
      answer.match_index   = 8'(best);
      answer.bypassed      = 1'b0;
      return answer;
   endfunction

   task automatic log_error(input string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want)
         log_error($sformatf("mismatch in %s: expected %h, got %h", name, want, got));
   endtask

   // Score each strobed result against the oldest outstanding lookup
   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (reset == 1'b0 && rsp_strobe !== 1'b0) begin
         if (pending_lookups.size() == 0) begin
            log_error($sformatf("unexpected result: code %h index %0d bypass %b",
                                rsp_item.throttle_code, rsp_item.match_index,
                                rsp_item.bypassed));
         end else begin
            want = pending_lookups.pop_front();
            check_field("throttle_code", 16'(want.throttle_code), 16'(rsp_item.throttle_code));
            check_field("match_index", 16'(want.match_index), 16'(rsp_item.match_index));
            check_field("bypassed", 16'(want.bypassed), 16'(rsp_item.bypassed));
         end
      end
   end

   // Hold an item on the request port until it transfers, then update the shadow state
   task automatic send_item(input req_item_type item);
      // before each item, keep the request side idle while a random draw falls under 31 of 100
      while (gaps_enabled && $urandom_range(0, 99) < 31) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      items_sent++;
      if (item.req_type == REQ_LOAD) begin
         cal_code[item.entry_index] = item.entry_reg_value;
         cal_bw[item.entry_index]   = item.entry_bandwidth;
      end else begin
         pending_lookups.push_back(nearest_code(item.target_bandwidth));
      end
   endtask

   // Drop start and let the block drain completely
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_lookups.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_pair_count(input logic [CNT_W-1:0] count);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cal_count = count;
   endtask

   // Fields that the item kind ignores still carry random bits
   function automatic req_item_type random_fields();
      req_item_type item;
      item.req_type         = REQ_LOAD;
      item.entry_index      = 8'($urandom);
      item.entry_reg_value  = 16'($urandom);
      item.entry_bandwidth  = $urandom;
      item.target_bandwidth = $urandom;
      return item;
   endfunction

   task automatic load_entry(input logic [7:0] idx, input logic [CODE_W-1:0] code,
                             input logic [BW_W-1:0] bw);
      req_item_type item;
      item                 = random_fields();
      item.req_type        = REQ_LOAD;
      item.entry_index     = idx;
      item.entry_reg_value = code;
      item.entry_bandwidth = bw;
      send_item(item);
   endtask

   task automatic query(input logic [BW_W-1:0] target);
      req_item_type item;
      item                  = random_fields();
      item.req_type         = REQ_QUERY;
      item.target_bandwidth = target;
      send_item(item);
   endtask

   // Mix wide values with clustered ones so near-ties show up
   function automatic logic [BW_W-1:0] random_bandwidth();
      case ($urandom_range(0, 7))
         0, 1:    return $urandom;
         2, 3, 4: return $urandom_range(0, 4095);
         5:       return cal_bw[$urandom_range(0, TABLE_DEPTH - 1)]
                         + BW_W'($urandom_range(0, 6)) - BW_W'(3);
         6:       return $urandom_range(0, 3);
         default: return BW_ALL_ONES - BW_W'($urandom_range(0, 3));
      endcase
   endfunction

   // Aim targets at, near and between entries inside the scanned range, plus bypass, edge and random values
   function automatic logic [BW_W-1:0] random_target();
      int            lim;
      logic [BW_W:0] sum;
      lim = (cal_count > DEPTH_CNT) ? TABLE_DEPTH : int'(cal_count);
      if (lim < 1)
         lim = 1;
      case ($urandom_range(0, 19))
         0:       return BW_ALL_ONES;
         1:       return '0;
         2:       return BW_ALL_ONES - BW_W'(1);
         3, 4, 5: begin
            sum = cal_bw[$urandom_range(0, lim - 1)] + cal_bw[$urandom_range(0, lim - 1)];
            return sum[BW_W:1];
         end
         6, 7, 8, 9, 10, 11: return cal_bw[$urandom_range(0, lim - 1)]
                                    + BW_W'($urandom_range(0, 16)) - BW_W'(8);
         12, 13:  return $urandom_range(0, 4095);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] random_count();
      case ($urandom_range(0, 19))
         0:       return DEPTH_CNT;
         1:       return CNT_W'($urandom_range(TABLE_DEPTH + 1, 511));
         2:       return '0;
         3:       return CNT_W'(1);
         4, 5:    return CNT_W'($urandom_range(41, TABLE_DEPTH - 1));
         default: return CNT_W'($urandom_range(2, 40));
      endcase
   endfunction

   task automatic run_phase(input int n_items, input int query_pct);
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(1, 100) <= query_pct)
            query(random_target());
         else
            load_entry(8'($urandom), 16'($urandom), random_bandwidth());
      end
   endtask

   // Empty and single-pair tables answer entry 0 without a scan
   task automatic test_count_zero_one();
      write_pair_count('0);
      load_entry(8'd0, 16'hffff, 32'h0000_0000);
      query(32'd5);
      query(32'd0);
      write_pair_count(CNT_W'(1));
      query(32'h7fff_ffff);
   endtask

   // Ties, zero target, bypass, and the target acting as the initial error
   task automatic test_nearest_search();
      load_entry(8'd1, 16'h0000, 32'd1000);
      load_entry(8'd2, 16'h1234, 32'd90);
      load_entry(8'd3, 16'h5678, 32'd110);
      load_entry(8'd4, 16'habcd, 32'hffff_ffff);
      load_entry(8'd255, 16'h5a5a, 32'h8000_0000);
      write_pair_count(CNT_W'(5));
      query(32'd100);
      query(32'd0);
      query(BW_ALL_ONES);
      query(32'hffff_fffe);
      query(32'd1000);
      query(32'd50);
      query(32'd20);
   endtask

   // Write every entry so any count is legal from here on
   task automatic test_fill_table();
      for (int i = 0; i < TABLE_DEPTH; i++)
         load_entry(8'(i), 16'($urandom), random_bandwidth());
   endtask

   // Full table, counts beyond the depth, one below the depth, smallest scan
   task automatic test_count_limits();
      write_pair_count(DEPTH_CNT);
      run_phase(25, 80);
      write_pair_count('1);
      run_phase(25, 80);
      write_pair_count(DEPTH_CNT - CNT_W'(1));
      run_phase(25, 80);
      write_pair_count(CNT_W'(2));
      run_phase(25, 80);
   endtask

   task automatic test_random_traffic();
      int phase;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         // leave a long stretch with no request gaps
         gaps_enabled = !(phase >= 8 && phase < 12);
         write_pair_count(random_count());
         run_phase(PHASE_ITEMS, 50);
         phase++;
      end
      gaps_enabled = 1'b1;
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_count_zero_one();
      test_nearest_search();
      test_fill_table();
      test_count_limits();
      test_random_traffic();

      wait_idle();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
